// ----- sv/polyline_bounding_box_assert.svh -----
// ---------------------------------------------------------------------------
// polyline_bounding_box_assert.svh
// assertion macros used by the checker file of the bounding box block
// ---------------------------------------------------------------------------
`ifndef POLYLINE_BOUNDING_BOX_ASSERT_SVH
`define POLYLINE_BOUNDING_BOX_ASSERT_SVH

// concurrent assertion on an explicit clock and active-low reset
`define PBB_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define PBB_ASSERT(lbl, prop, msg) `PBB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/pbb_pkg.sv -----
// ---------------------------------------------------------------------------
// pbb_pkg
// types and constants shared by the polyline bounding box modules
// ---------------------------------------------------------------------------
`default_nettype none

package pbb_pkg;

  // field widths fixed by the interface
  localparam int unsigned CENTER_W = 32;
  localparam int unsigned EXTENT_W = 31;
  localparam int unsigned POINT_W  = 32;
  localparam int unsigned LW_W     = 31;
  localparam int unsigned NOISE_W  = 30;
  localparam int unsigned SUBDIV_W = 8;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // extent of a line with fewer than two points, 1.0 in Q15.16
  localparam logic [EXTENT_W-1:0] EXTENT_ONE = 31'h0001_0000;

  // queue depth between front and back, and back pipeline stages after it
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PIPE_STAGES = 4;

  // register map, index = byte address / 4
  typedef enum logic [1:0] {
    REG_LINE_WIDTH      = 2'd0,
    REG_NOISE_AMPLITUDE = 2'd1,
    REG_SUBDIV_LEVELS   = 2'd2
  } pbb_reg_e;

  // position of a point within its line
  typedef enum logic [1:0] {
    ROLE_FIRST  = 2'd0,
    ROLE_SECOND = 2'd1,
    ROLE_LATER  = 2'd2
  } pbb_role_e;

  // classification tag that travels with a point
  typedef struct packed {
    pbb_role_e role;
    logic      is_final;
  } pbb_tag_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [LW_W-1:0]    line_width;
    logic [NOISE_W-1:0] noise_amplitude;
    logic               sub_en;
  } pbb_cfg_t;

endpackage

`default_nettype wire

// ----- sv/pbb_point_if.sv -----
// ---------------------------------------------------------------------------
// pbb_point_if
// point channel: one polyline vertex per transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface pbb_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               is_final;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output is_final, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input is_final, output ready);
endinterface

`default_nettype wire

// ----- sv/pbb_result_if.sv -----
// ---------------------------------------------------------------------------
// pbb_result_if
// result channel: one bounding box per transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface pbb_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic        [30:0] extent_x;
  logic        [30:0] extent_y;
  logic        [30:0] extent_z;
  logic               line_valid;

  modport source (output valid, output center_x, output center_y, output center_z,
                  output extent_x, output extent_y, output extent_z,
                  output line_valid, input ready);
  modport sink   (input valid, input center_x, input center_y, input center_z,
                  input extent_x, input extent_y, input extent_z,
                  input line_valid, output ready);
endinterface

`default_nettype wire

// ----- sv/pbb_front.sv -----
// ---------------------------------------------------------------------------
// pbb_front
// accepts points, clamps them to the coordinate range and tags their role
// ---------------------------------------------------------------------------
`default_nettype none

module pbb_front #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pbb_point_if.sink                      point_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output logic [2:0][COORD_BITS-1:0]     q_pt_o,
  output pbb_pkg::pbb_tag_t              q_tag_o
);
  import pbb_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned IW = (CW > POINT_W) ? CW : POINT_W;
  localparam logic signed [IW-1:0] CMAX_I = IW'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [IW-1:0] CMIN_I = IW'(-(64'sd1 <<< (CW-1)));

  pbb_role_e          role_q, role_d;
  logic               push;
  logic signed [31:0] raw [3];
  logic signed [IW-1:0] wide [3];

  assign raw[0] = point_i.point_x;
  assign raw[1] = point_i.point_y;
  assign raw[2] = point_i.point_z;

  assign point_i.ready = q_ready_i;
  assign push          = point_i.valid && q_ready_i;

  // clamp each coordinate into the internal range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = IW'(raw[i]);
      if (wide[i] > CMAX_I) begin
        wide[i] = CMAX_I;
      end else if (wide[i] < CMIN_I) begin
        wide[i] = CMIN_I;
      end
      q_pt_o[i] = CW'(wide[i]);
    end
  end

  // role sequence: first, second, later; a final point restarts the line
  always_comb begin
    role_d = role_q;
    if (push) begin
      if (point_i.is_final) begin
        role_d = ROLE_FIRST;
      end else begin
        unique case (role_q)
          ROLE_FIRST:  role_d = ROLE_SECOND;
          ROLE_SECOND: role_d = ROLE_LATER;
          ROLE_LATER:  role_d = ROLE_LATER;
          default:     role_d = ROLE_FIRST;
        endcase
      end
    end
  end

  // tag and queue write
  always_comb begin
    q_valid_o        = point_i.valid;
    q_tag_o.role     = role_q;
    q_tag_o.is_final = point_i.is_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q <= ROLE_FIRST;
    end else begin
      role_q <= role_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pbb_queue.sv -----
// ---------------------------------------------------------------------------
// pbb_queue
// small first-in first-out queue between the front and the back end
// ---------------------------------------------------------------------------
`default_nettype none

module pbb_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL = NW'(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pbb_back.sv -----
// ---------------------------------------------------------------------------
// pbb_back
// running point and midpoint boxes, then the finishing pipeline per line
// ---------------------------------------------------------------------------
`default_nettype none

module pbb_back #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  logic [2:0][COORD_BITS-1:0] q_pt_i,
  input  pbb_pkg::pbb_tag_t          q_tag_i,
  input  pbb_pkg::pbb_cfg_t          cfg_i,
  pbb_result_if.source               result_o
);
  import pbb_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned SW = CW + 1;
  localparam int unsigned GW = ((CW > 32) ? CW : 32) + 2;
  localparam int unsigned OW = ((CW > CENTER_W) ? CW : CENTER_W) + 1;
  localparam int unsigned EW = ((CW > EXTENT_W) ? CW : EXTENT_W) + 1;

  localparam logic signed [GW-1:0] CMAX_G = GW'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [GW-1:0] CMIN_G = GW'(-(64'sd1 <<< (CW-1)));
  localparam logic signed [OW-1:0] OMAX   = OW'(64'sd2147483647);
  localparam logic signed [OW-1:0] OMIN   = OW'(-64'sd2147483648);
  localparam logic        [EW-1:0] EMAX   = EW'(64'd2147483647);

  // saturate a widened coordinate back into the internal range
  function automatic logic signed [CW-1:0] sat_c(input logic signed [GW-1:0] v);
    logic signed [GW-1:0] r;
    r = v;
    if (r > CMAX_G) begin
      r = CMAX_G;
    end else if (r < CMIN_G) begin
      r = CMIN_G;
    end
    return CW'(r);
  endfunction

  // running state
  logic signed [CW-1:0] prev_q [3];
  logic signed [CW-1:0] pmin_q [3], pmax_q [3], mmin_q [3], mmax_q [3];
  logic signed [CW-1:0] pmin_d [3], pmax_d [3], mmin_d [3], mmax_d [3];
  logic signed [CW-1:0] pt     [3];
  logic signed [CW-1:0] mid    [3];
  logic signed [SW-1:0] msum   [3];

  // finishing pipeline
  logic                 s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic                 s1_adv, s2_adv, s3_adv, out_adv;
  logic                 pop, pop_final;
  logic                 s1_lv_q, s2_lv_q, s3_lv_q, out_lv_q;
  logic                 s2_sub_q;
  logic signed [CW-1:0] s1_pmin_q [3], s1_pmax_q [3], s1_mmin_q [3], s1_mmax_q [3];
  logic signed [CW-1:0] s2_loa_q [3], s2_hia_q [3], s2_lob_q [3], s2_hib_q [3];
  logic signed [CW-1:0] loa [3], hia [3], lob [3], hib [3];
  logic signed [CW-1:0] lo [3], hi [3];
  logic signed [SW-1:0] s3_sum_q [3], s3_diff_q [3];
  logic signed [SW-1:0] sum [3], diff [3];
  logic signed [CW-1:0] ctr [3];
  logic        [CW-1:0] ext [3];
  logic signed [OW-1:0] ctr_w [3];
  logic        [EW-1:0] ext_w [3];
  logic signed [CENTER_W-1:0] ctr_n [3], out_ctr_q [3];
  logic        [EXTENT_W-1:0] ext_n [3], out_ext_q [3];
  logic        [NOISE_W-1:0]  grow;
  logic        [31:0]         grow2;
  logic signed [GW-1:0]       grow_g, grow2_g;

  // handshake between stages; a final point needs room in the first stage
  assign out_adv   = !out_v_q || result_o.ready;
  assign s3_adv    = !s3_v_q || out_adv;
  assign s2_adv    = !s2_v_q || s3_adv;
  assign s1_adv    = !s1_v_q || s2_adv;
  assign q_ready_o = !q_tag_i.is_final || s1_adv;
  assign pop       = q_valid_i && q_ready_o;
  assign pop_final = pop && q_tag_i.is_final;

  // box update with the popped point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i]   = signed'(q_pt_i[i]);
      msum[i] = SW'(prev_q[i]) + SW'(pt[i]);
      mid[i]  = signed'(msum[i][CW:1]);
      pmin_d[i] = (pt[i] < pmin_q[i]) ? pt[i] : pmin_q[i];
      pmax_d[i] = (pt[i] > pmax_q[i]) ? pt[i] : pmax_q[i];
      mmin_d[i] = (mid[i] < mmin_q[i]) ? mid[i] : mmin_q[i];
      mmax_d[i] = (mid[i] > mmax_q[i]) ? mid[i] : mmax_q[i];
      unique case (q_tag_i.role)
        ROLE_SECOND: begin
          mmin_d[i] = mid[i];
          mmax_d[i] = mid[i];
        end
        ROLE_LATER: begin
        end
        default: begin
          pmin_d[i] = pt[i];
          pmax_d[i] = pt[i];
          mmin_d[i] = mmin_q[i];
          mmax_d[i] = mmax_q[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= pt[i];
        pmin_q[i] <= pmin_d[i];
        pmax_q[i] <= pmax_d[i];
        mmin_q[i] <= mmin_d[i];
        mmax_q[i] <= mmax_d[i];
      end
    end
  end

  // enlargement of both boxes with saturation
  always_comb begin
    grow    = cfg_i.line_width[LW_W-1:1];
    grow2   = 32'(grow) + 32'({cfg_i.noise_amplitude, 1'b0});
    grow_g  = signed'(GW'(grow));
    grow2_g = signed'(GW'(grow2));
    for (int i = 0; i < 3; i++) begin
      loa[i] = sat_c(GW'(s1_pmin_q[i]) - grow_g);
      hia[i] = sat_c(GW'(s1_pmax_q[i]) + grow_g);
      lob[i] = sat_c(GW'(s1_mmin_q[i]) - grow2_g);
      hib[i] = sat_c(GW'(s1_mmax_q[i]) + grow2_g);
    end
  end

  // union with the midpoint box when subdivision is on, then center sums and width differences
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo[i]   = (s2_sub_q && (s2_lob_q[i] < s2_loa_q[i])) ? s2_lob_q[i] : s2_loa_q[i];
      hi[i]   = (s2_sub_q && (s2_hib_q[i] > s2_hia_q[i])) ? s2_hib_q[i] : s2_hia_q[i];
      sum[i]  = SW'(hi[i]) + SW'(lo[i]);
      diff[i] = SW'(hi[i]) - SW'(lo[i]);
    end
  end

  // halve and saturate to the result fields; a short line gets the default box
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr[i]   = signed'(s3_sum_q[i][CW:1]);
      ext[i]   = s3_diff_q[i][CW:1];
      ctr_w[i] = OW'(ctr[i]);
      ext_w[i] = EW'(ext[i]);
      if (ctr_w[i] > OMAX) begin
        ctr_w[i] = OMAX;
      end else if (ctr_w[i] < OMIN) begin
        ctr_w[i] = OMIN;
      end
      if (ext_w[i] > EMAX) begin
        ext_w[i] = EMAX;
      end
      ctr_n[i] = CENTER_W'(ctr_w[i]);
      ext_n[i] = EXTENT_W'(ext_w[i]);
      if (!s3_lv_q) begin
        ctr_n[i] = '0;
        ext_n[i] = EXTENT_ONE;
      end
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= pop_final;
      end
      if (s2_adv) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_adv) begin
        s3_v_q <= s2_v_q;
      end
      if (out_adv) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_lv_q <= (q_tag_i.role != ROLE_FIRST);
      for (int i = 0; i < 3; i++) begin
        s1_pmin_q[i] <= pmin_d[i];
        s1_pmax_q[i] <= pmax_d[i];
        s1_mmin_q[i] <= mmin_d[i];
        s1_mmax_q[i] <= mmax_d[i];
      end
    end
    if (s2_adv) begin
      s2_lv_q  <= s1_lv_q;
      s2_sub_q <= cfg_i.sub_en;
      for (int i = 0; i < 3; i++) begin
        s2_loa_q[i] <= loa[i];
        s2_hia_q[i] <= hia[i];
        s2_lob_q[i] <= lob[i];
        s2_hib_q[i] <= hib[i];
      end
    end
    if (s3_adv) begin
      s3_lv_q <= s2_lv_q;
      for (int i = 0; i < 3; i++) begin
        s3_sum_q[i]  <= sum[i];
        s3_diff_q[i] <= diff[i];
      end
    end
    if (out_adv) begin
      out_lv_q <= s3_lv_q;
      for (int i = 0; i < 3; i++) begin
        out_ctr_q[i] <= ctr_n[i];
        out_ext_q[i] <= ext_n[i];
      end
    end
  end

  // result channel
  assign result_o.valid      = out_v_q;
  assign result_o.line_valid = out_lv_q;
  assign result_o.center_x   = out_ctr_q[0];
  assign result_o.center_y   = out_ctr_q[1];
  assign result_o.center_z   = out_ctr_q[2];
  assign result_o.extent_x   = out_ext_q[0];
  assign result_o.extent_y   = out_ext_q[1];
  assign result_o.extent_z   = out_ext_q[2];

endmodule

`default_nettype wire

// ----- sv/polyline_bounding_box.sv -----
// ---------------------------------------------------------------------------
// polyline_bounding_box
// axis-aligned 3D bounding box of a polyline, given as center and half-extent
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   point_i   in         valid / ready        point_x/y/z, is_final
//   result_o  out        valid / ready        center_x/y/z, extent_x/y/z, line_valid
//   apb       in         psel/penable/pwrite  paddr, pwdata, prdata
//
// one point per cycle sustained while no final point waits on a stalled result
// a final point's box passes the queue, then stages s1, s2, s3 and out, to result_o
// reset clears the config registers, the queue and the pipeline valid flags
// a stalled result holds the pipeline, then the two-entry queue fills, then
// point_i.ready drops; non-final points keep flowing while only the result waits
// ---------------------------------------------------------------------------
`default_nettype none

module polyline_bounding_box #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pbb_point_if.sink                   point_i,
  pbb_result_if.source                result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pbb_pkg::APB_AW-1:0]  paddr,
  input  logic [pbb_pkg::APB_DW-1:0]  pwdata,
  output logic [pbb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import pbb_pkg::*;

  localparam int unsigned QW = 3 * COORD_BITS + $bits(pbb_tag_t);

  logic [LW_W-1:0]     lw_q;
  logic [NOISE_W-1:0]  na_q;
  logic [SUBDIV_W-1:0] sl_q;
  logic [1:0]          reg_idx;
  logic                cfg_wr;
  pbb_cfg_t            cfg;

  logic                       f_valid, f_ready;
  logic [2:0][COORD_BITS-1:0] f_pt, b_pt;
  pbb_tag_t                   f_tag, b_tag;
  logic                       b_valid, b_ready;
  logic [QW-1:0]              b_data;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= '0;
      na_q <= '0;
      sl_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LINE_WIDTH:      lw_q <= pwdata[LW_W-1:0];
        REG_NOISE_AMPLITUDE: na_q <= pwdata[NOISE_W-1:0];
        REG_SUBDIV_LEVELS:   sl_q <= pwdata[SUBDIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_LINE_WIDTH:      prdata = APB_DW'(lw_q);
      REG_NOISE_AMPLITUDE: prdata = APB_DW'(na_q);
      REG_SUBDIV_LEVELS:   prdata = APB_DW'(sl_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg.line_width      = lw_q;
  assign cfg.noise_amplitude = na_q;
  assign cfg.sub_en          = |sl_q;

  // front: accept, clamp, classify
  pbb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .point_i   (point_i),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_pt_o    (f_pt),
    .q_tag_o   (f_tag)
  );

  // queue between front and back
  pbb_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  ({f_tag, f_pt}),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_data)
  );

  assign {b_tag, b_pt} = b_data;

  // back: boxes and finishing pipeline
  pbb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (b_valid),
    .q_ready_o (b_ready),
    .q_pt_i    (b_pt),
    .q_tag_i   (b_tag),
    .cfg_i     (cfg),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

// ----- sv/pbb_checker.sv -----
// ---------------------------------------------------------------------------
// pbb_checker
// port-level checks of the polyline bounding box, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "polyline_bounding_box_assert.svh"

module pbb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_final_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              line_valid_i,
  input logic signed [pbb_pkg::CENTER_W-1:0] center_x_i,
  input logic signed [pbb_pkg::CENTER_W-1:0] center_y_i,
  input logic signed [pbb_pkg::CENTER_W-1:0] center_z_i,
  input logic        [pbb_pkg::EXTENT_W-1:0] extent_x_i,
  input logic        [pbb_pkg::EXTENT_W-1:0] extent_y_i,
  input logic        [pbb_pkg::EXTENT_W-1:0] extent_z_i
);
  import pbb_pkg::*;

  localparam logic [3:0] MAX_PEND = 4'(QUEUE_DEPTH + PIPE_STAGES);

  logic       in_xfer, out_xfer, fin_xfer;
  logic [3:0] pend_q, pend_d;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign fin_xfer = in_xfer && in_final_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // final points taken whose box has not been delivered yet
  always_comb begin
    pend_d = pend_q;
    if (fin_xfer && !out_xfer) begin
      pend_d = pend_q + 1'b1;
    end else if (out_xfer && !fin_xfer) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `PBB_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `PBB_ASSERT(a_default_box, out_valid_i && !line_valid_i |-> center_x_i == 0 && center_y_i == 0 && center_z_i == 0 && extent_x_i == EXTENT_ONE && extent_y_i == EXTENT_ONE && extent_z_i == EXTENT_ONE, "short line box is not the default")
  `PBB_ASSERT(a_no_orphan, out_xfer |-> pend_q != 0, "result without a final point")
  `PBB_ASSERT(a_pend_bound, pend_q <= MAX_PEND, "more lines in flight than storage")

endmodule

bind polyline_bounding_box pbb_checker u_pbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (point_i.valid),
  .in_ready_i   (point_i.ready),
  .in_final_i   (point_i.is_final),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .line_valid_i (result_o.line_valid),
  .center_x_i   (result_o.center_x),
  .center_y_i   (result_o.center_y),
  .center_z_i   (result_o.center_z),
  .extent_x_i   (result_o.extent_x),
  .extent_y_i   (result_o.extent_y),
  .extent_z_i   (result_o.extent_z)
);

`default_nettype wire

// ----- tb/tb_polyline_bounding_box.sv -----
// ---------------------------------------------------------------------------
// tb_polyline_bounding_box
// self-checking testbench of the polyline bounding box block
// ---------------------------------------------------------------------------
// streams polylines into the point channel with random gaps and stalls the
// result channel at random. A built-in bounding box calculator predicts the
// box of every final point, and each result transfer is compared field by
// field against the oldest due box. A short directed table comes first,
// then phases of random lines, each under its own register setting.
// ---------------------------------------------------------------------------

module tb_polyline_bounding_box;
  import pbb_pkg::*;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t      cx;
    coord_t      cy;
    coord_t      cz;
    logic [30:0] ex;
    logic [30:0] ey;
    logic [30:0] ez;
    logic        lv;
  } box_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   fin;
    logic   typed;
    box_t   bx;
  } stim_row_t;

  localparam coord_t      C_MAX        = 32'sh7FFF_FFFF;
  localparam coord_t      C_MIN        = 32'sh8000_0000;
  localparam logic [30:0] E_MAX        = 31'h7FFF_FFFF;
  localparam int          N_PHASES     = 10;
  localparam int          PHASE_ITEMS  = 190;
  localparam int          DRAIN_CYCLES = PIPE_STAGES + QUEUE_DEPTH + 12;
  localparam int          MAX_SHOWN    = 10;
  localparam longint      RUN_LIMIT    = 2_500_000;

  // fixed boxes used by the directed table
  localparam box_t NO_BOX    = '0;
  localparam box_t SHORT_BOX = '{32'sd0, 32'sd0, 32'sd0, EXTENT_ONE, EXTENT_ONE, EXTENT_ONE,
                                 1'b0};
  localparam box_t FULL_BOX  = '{-32'sd1, -32'sd1, -32'sd1, E_MAX, E_MAX, E_MAX, 1'b1};

  // directed stimulus: extremes, short lines, rounding of odd negative sums,
  // saturation of the point count and a new line right after a final point
  stim_row_t dir_tab [18] = '{
    '{32'sd0,        32'sd0,        32'sd0,        1'b1, 1'b1, SHORT_BOX},
    '{C_MAX,         C_MIN,         -32'sd1,       1'b1, 1'b1, SHORT_BOX},
    '{C_MIN,         C_MIN,         C_MIN,         1'b0, 1'b0, NO_BOX},
    '{C_MAX,         C_MAX,         C_MAX,         1'b1, 1'b1, FULL_BOX},
    '{C_MAX,         C_MIN,         32'sd0,        1'b0, 1'b0, NO_BOX},
    '{C_MIN,         C_MAX,         32'sd0,        1'b1, 1'b1,
      '{-32'sd1, -32'sd1, 32'sd0, E_MAX, E_MAX, 31'd0, 1'b1}},
    '{32'sd1,        32'sd1,        32'sd1,        1'b0, 1'b0, NO_BOX},
    '{32'sd1,        32'sd1,        32'sd1,        1'b1, 1'b1,
      '{32'sd1, 32'sd1, 32'sd1, 31'd0, 31'd0, 31'd0, 1'b1}},
    '{-32'sd3,       32'sd5,        32'sd1,        1'b0, 1'b0, NO_BOX},
    '{-32'sd4,       -32'sd6,       32'sd2,        1'b0, 1'b0, NO_BOX},
    '{32'sd7,        32'sd0,        -32'sd1,       1'b0, 1'b0, NO_BOX},
    '{-32'sd1,       -32'sd1,       -32'sd1,       1'b0, 1'b0, NO_BOX},
    '{32'sd2,        32'sd3,        -32'sd5,       1'b1, 1'b0, NO_BOX},
    '{-32'sd1,       -32'sd1,       -32'sd1,       1'b0, 1'b0, NO_BOX},
    '{32'sd0,        32'sd0,        32'sd0,        1'b1, 1'b1,
      '{-32'sd1, -32'sd1, -32'sd1, 31'd0, 31'd0, 31'd0, 1'b1}},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1'b0, 1'b0, NO_BOX},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0, 1'b1, 1'b0, NO_BOX},
    '{C_MAX,         32'sd0,        C_MIN,         1'b1, 1'b1, SHORT_BOX}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  pbb_point_if  pt_if ();
  pbb_result_if box_if ();

  polyline_bounding_box DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pt_if),
    .result_o (box_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register copies and running state of the bounding box calculator
  logic [30:0] cfg_width;
  logic [29:0] cfg_noise;
  logic [7:0]  cfg_levels;
  logic [1:0]  pts_seen;
  coord_t      last_pt [3];
  coord_t      pbox_lo [3];
  coord_t      pbox_hi [3];
  coord_t      mbox_lo [3];
  coord_t      mbox_hi [3];

  box_t        boxes_due [$];
  int unsigned mismatches;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // clamp to the coordinate range
  function automatic longint sat_coord(input longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  // fold one point into the running boxes, give the box on a final point
  function automatic bit bbox_update(input coord_t pin [3], input logic fin,
                                     output box_t bx);
    longint      mid;
    longint      grow;
    longint      grow2;
    longint      lo;
    longint      hi;
    coord_t      ctr [3];
    logic [30:0] ext [3];
    bx = '0;
    for (int i = 0; i < 3; i++) begin
      if (pts_seen == 2'd0) begin
        pbox_lo[i] = pin[i];
        pbox_hi[i] = pin[i];
      end else begin
        mid = (longint'(last_pt[i]) + longint'(pin[i])) >>> 1;
        if (pin[i] < pbox_lo[i]) pbox_lo[i] = pin[i];
        if (pin[i] > pbox_hi[i]) pbox_hi[i] = pin[i];
        if (pts_seen == 2'd1) begin
          mbox_lo[i] = coord_t'(mid);
          mbox_hi[i] = coord_t'(mid);
        end else begin
          if (mid < mbox_lo[i]) mbox_lo[i] = coord_t'(mid);
          if (mid > mbox_hi[i]) mbox_hi[i] = coord_t'(mid);
        end
      end
      last_pt[i] = pin[i];
    end
    if (pts_seen < 2'd2) pts_seen = pts_seen + 2'd1;
    if (!fin) return 1'b0;

    if (pts_seen < 2'd2) begin
      bx = SHORT_BOX;
    end else begin
      grow = 0;
      grow[29:0] = cfg_width[30:1];
      grow2 = grow + 2 * longint'({34'd0, cfg_noise});
      for (int i = 0; i < 3; i++) begin
        lo = sat_coord(longint'(pbox_lo[i]) - grow);
        hi = sat_coord(longint'(pbox_hi[i]) + grow);
        // midpoint box joins in when subdivision is on
        if (cfg_levels != 8'd0) begin
          if (sat_coord(longint'(mbox_lo[i]) - grow2) < lo)
            lo = sat_coord(longint'(mbox_lo[i]) - grow2);
          if (sat_coord(longint'(mbox_hi[i]) + grow2) > hi)
            hi = sat_coord(longint'(mbox_hi[i]) + grow2);
        end
        ctr[i] = coord_t'((hi + lo) >>> 1);
        ext[i] = 31'((hi - lo) >>> 1);
      end
      bx = '{ctr[0], ctr[1], ctr[2], ext[0], ext[1], ext[2], 1'b1};
    end
    pts_seen = 2'd0;
    return 1'b1;
  endfunction

  // random coordinate in one of several flavors
  function automatic coord_t pick_coord(input int style, input coord_t base);
    case (style)
      0: return coord_t'($urandom);
      1: return base + coord_t'($urandom_range(0, 8191)) - 32'sd4096;
      2: begin
        case ($urandom_range(0, 5))
          0: return C_MAX;
          1: return C_MIN;
          2: return C_MAX - 32'sd1;
          3: return C_MIN + 32'sd1;
          4: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) return C_MAX - coord_t'($urandom_range(0, 1 << 20));
        return C_MIN + coord_t'($urandom_range(0, 1 << 20));
      end
    endcase
  endfunction

  // register write, setup then access phase
  task automatic reg_write(input pbb_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LINE_WIDTH:      cfg_width  = val[30:0];
      REG_NOISE_AMPLITUDE: cfg_noise  = val[29:0];
      REG_SUBDIV_LEVELS:   cfg_levels = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one point transfer after an optional gap, then predict its box
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input logic fin, input int gap,
                            output bit produced, output box_t bx);
    coord_t pin [3];
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt_if.valid    <= 1'b1;
    pt_if.point_x  <= x;
    pt_if.point_y  <= y;
    pt_if.point_z  <= z;
    pt_if.is_final <= fin;
    do @(posedge clk_i); while (pt_if.ready !== 1'b1);
    pin[0] = x;
    pin[1] = y;
    pin[2] = z;
    produced = bbox_update(pin, fin, bx);
  endtask

  // stop sending, let every due box arrive, then let the pipeline settle
  task automatic wait_idle();
    pt_if.valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // compare one result transfer against the oldest due box
  task automatic check_box(input box_t got);
    box_t want;
    if (boxes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("unexpected box: c=(%0d,%0d,%0d) e=(%0d,%0d,%0d) v=%0b",
                 got.cx, got.cy, got.cz, got.ex, got.ey, got.ez, got.lv);
      return;
    end
    want = boxes_due.pop_front();
    if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
        got.ex !== want.ex || got.ey !== want.ey || got.ez !== want.ez ||
        got.lv !== want.lv) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("box mismatch: expected c=(%0d,%0d,%0d) e=(%0d,%0d,%0d) v=%0b, got c=(%0d,%0d,%0d) e=(%0d,%0d,%0d) v=%0b",
                 want.cx, want.cy, want.cz, want.ex, want.ey, want.ez, want.lv,
                 got.cx, got.cy, got.cz, got.ex, got.ey, got.ez, got.lv);
    end
  endtask

  // result side: random stall before each transfer, idle-free stretches too
  initial begin
    int   stall;
    bit   sink_idle;
    box_t got;
    sink_idle = 1'b1;
    box_if.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) sink_idle = !sink_idle;
      stall = sink_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        box_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      box_if.ready <= 1'b1;
      do @(posedge clk_i); while (box_if.valid !== 1'b1 || rst_ni !== 1'b1);
      got = '{box_if.center_x, box_if.center_y, box_if.center_z,
              box_if.extent_x, box_if.extent_y, box_if.extent_z, box_if.line_valid};
      check_box(got);
    end
  end

  // stimulus
  initial begin
    box_t        bx;
    bit          produced;
    bit          src_idle;
    int          gap;
    int          style;
    int          len;
    int          sent;
    int          pick;
    coord_t      base [3];
    coord_t      p [3];
    logic [31:0] w_val;
    logic [31:0] n_val;
    logic [31:0] l_val;

    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    pt_if.valid    <= 1'b0;
    pt_if.point_x  <= '0;
    pt_if.point_y  <= '0;
    pt_if.point_z  <= '0;
    pt_if.is_final <= 1'b0;
    mismatches = 0;
    src_idle   = 1'b1;
    cfg_width  = '0;
    cfg_noise  = '0;
    cfg_levels = '0;
    pts_seen   = '0;
    for (int i = 0; i < 3; i++) begin
      last_pt[i] = '0;
      pbox_lo[i] = '0;
      pbox_hi[i] = '0;
      mbox_lo[i] = '0;
      mbox_hi[i] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset register values
    foreach (dir_tab[k]) begin
      gap = $urandom_range(0, 4);
      send_point(dir_tab[k].x, dir_tab[k].y, dir_tab[k].z, dir_tab[k].fin, gap,
                 produced, bx);
      if (produced) boxes_due.push_back(dir_tab[k].typed ? dir_tab[k].bx : bx);
    end
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          w_val = 32'h7FFF_FFFF; n_val = 32'h3FFF_FFFF; l_val = 32'd255;
        end
        1: begin
          w_val = 32'd0; n_val = 32'd0; l_val = 32'd0;
        end
        2: begin
          w_val = 32'h7FFF_FFFF; n_val = 32'd0; l_val = 32'd1;
        end
        3: begin
          w_val = 32'd1; n_val = 32'd1; l_val = 32'd0;
        end
        default: begin
          w_val = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h7_FFFF);
          n_val = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h3_FFFF);
          l_val = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 255);
        end
      endcase
      // upper bits beyond the register widths are written too
      reg_write(REG_LINE_WIDTH, w_val);
      reg_write(REG_NOISE_AMPLITUDE, n_val);
      reg_write(REG_SUBDIV_LEVELS, l_val);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // line shape: mostly medium lines, some single points, some long
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 1;
        else if (pick < 85) len = $urandom_range(2, 6);
        else len = $urandom_range(7, 20);
        style = $urandom_range(0, 3);
        for (int a = 0; a < 3; a++) base[a] = coord_t'($urandom);
        if ($urandom_range(0, 7) == 0) src_idle = !src_idle;
        for (int j = 0; j < len; j++) begin
          for (int a = 0; a < 3; a++)
            p[a] = ($urandom_range(0, 15) == 0) ? pick_coord(0, base[a])
                                                : pick_coord(style, base[a]);
          gap = src_idle ? $urandom_range(0, 4) : 0;
          send_point(p[0], p[1], p[2], (j == len - 1), gap, produced, bx);
          if (produced) boxes_due.push_back(bx);
        end
        sent += len;
      end
      wait_idle();
    end

    if (mismatches == 0 && boxes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
